// ----- rtl/rhce_pkg.sv -----
// Shared constants and types for the rolling hash chunk length encoder.
`default_nettype none

package rhce_pkg;

    localparam int HASH_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH          = 16;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int RUN_WIDTH          = 30;
    localparam int MAX_CODE           = 5;
    localparam int CODE_COUNT_WIDTH   = $clog2(MAX_CODE + 1);
    localparam int FIFO_DEPTH         = 8;

    localparam logic [RUN_WIDTH-1:0] RUN_MAX    = 30'd539000895;
    localparam logic [RUN_WIDTH-1:0] LEN_TWO    = 30'd64;
    localparam logic [RUN_WIDTH-1:0] LEN_THREE  = 30'd32832;
    localparam logic [RUN_WIDTH-1:0] LEN_FOUR   = 30'd2129984;

    localparam logic [7:0] SHORT_BASE = 8'd128;
    localparam logic [7:0] THREE_BASE = 8'd192;
    localparam logic [7:0] FOUR_BASE  = 8'd224;
    localparam logic [7:0] END_MARK   = 8'd128;

    localparam logic                 ENABLE_RESET = 1'b1;
    localparam logic [CFG_WIDTH-1:0] MASK_RESET   = 16'd4095;
    localparam logic [CFG_WIDTH-1:0] HIT_RESET    = 16'd2047;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_MASK   = 2'd1,
        CFG_HIT    = 2'd2
    } cfg_index_t;

    // All code bytes caused by one input word, first byte at index 0.
    typedef struct packed {
        logic [MAX_CODE-1:0][7:0]      bytes;
        logic [CODE_COUNT_WIDTH-1:0]   count;
    } code_rec_t;

endpackage

`default_nettype wire

// ----- rtl/rhce_encoder.sv -----
// Variable-length run code and end marker builder for one input word.
`default_nettype none

module rhce_encoder
    import rhce_pkg::*;
(
    input  logic [RUN_WIDTH-1:0] run_len,
    input  logic                 hit,
    input  logic                 close,
    output code_rec_t            rec
);

    logic [RUN_WIDTH-1:0]        offset;
    logic [RUN_WIDTH-1:0]        diff;
    logic [3:0][7:0]             len_bytes;
    logic [CODE_COUNT_WIDTH-1:0] len_count;
    logic [CODE_COUNT_WIDTH-1:0] pos;

    always_comb
    begin
        if (run_len < LEN_TWO)
        begin
            offset = '0;
        end
        else if (run_len < LEN_THREE)
        begin
            offset = LEN_TWO;
        end
        else if (run_len < LEN_FOUR)
        begin
            offset = LEN_THREE;
        end
        else
        begin
            offset = LEN_FOUR;
        end
        diff = run_len - offset;
    end

    always_comb
    begin
        len_bytes = '0;
        if (run_len < LEN_TWO)
        begin
            len_bytes[0] = diff[7:0] + SHORT_BASE;
            len_count    = CODE_COUNT_WIDTH'(1);
        end
        else if (run_len < LEN_THREE)
        begin
            len_bytes[0] = diff[15:8];
            len_bytes[1] = diff[7:0];
            len_count    = CODE_COUNT_WIDTH'(2);
        end
        else if (run_len < LEN_FOUR)
        begin
            len_bytes[0] = diff[23:16] + THREE_BASE;
            len_bytes[1] = diff[15:8];
            len_bytes[2] = diff[7:0];
            len_count    = CODE_COUNT_WIDTH'(3);
        end
        else
        begin
            len_bytes[0] = {2'b00, diff[29:24]} + FOUR_BASE;
            len_bytes[1] = diff[23:16];
            len_bytes[2] = diff[15:8];
            len_bytes[3] = diff[7:0];
            len_count    = CODE_COUNT_WIDTH'(4);
        end
    end

    always_comb
    begin
        rec = '0;
        pos = '0;
        if (hit)
        begin
            rec.bytes[3:0] = len_bytes;
            pos            = len_count;
        end
        if (close)
        begin
            rec.bytes[pos] = END_MARK;
            rec.count      = pos + CODE_COUNT_WIDTH'(1);
        end
        else
        begin
            rec.count = pos;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rolling_hash_chunk_length_encoder.sv -----
// Top level of the rolling hash chunk length encoder.
`default_nettype none

// Takes one data word per cycle while data_stall is low; each word goes
// through an input register and a hash/count register, and its code bytes
// (one to five, if any) are then written as one record into an eight-record
// output queue. The output side hands out one code byte per cycle while
// code_stall is low. data_stall rises only when the queue plus the words in
// flight in those two registers would reach eight records. Registers are
// to be written through cfg_write/cfg_index/cfg_data only while idle, which
// the block does not enforce; an index beyond the register list is ignored.
module rolling_hash_chunk_length_encoder
    import rhce_pkg::*;
#(
    parameter int HASH_WIDTH = HASH_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic                       data_valid,
    output logic                       data_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       close_list,
    output logic                       code_valid,
    input  logic                       code_stall,
    output logic [7:0]                 code_byte,
    output logic                       last_of_run
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                  enable_reg;
    logic [CFG_WIDTH-1:0]  mask_reg;
    logic [CFG_WIDTH-1:0]  hit_reg;

    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;
    logic                  s1_close_reg;

    logic [HASH_WIDTH-1:0] hash_reg;
    logic [HASH_WIDTH-1:0] hash_next;
    logic [RUN_WIDTH-1:0]  run_reg;
    logic [RUN_WIDTH-1:0]  run_inc;
    logic [RUN_WIDTH-1:0]  run_next;
    logic [HASH_WIDTH-1:0] mask_w;
    logic [HASH_WIDTH-1:0] hit_w;
    logic                  hit_now;

    logic                  s2_valid_reg;
    logic                  s2_hit_reg;
    logic                  s2_close_reg;
    logic [RUN_WIDTH-1:0]  s2_len_reg;

    code_rec_t             enc_rec;
    code_rec_t             rec_mem [FIFO_DEPTH];
    code_rec_t             head;
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [CNT_W:0]        occupancy;
    logic [CODE_COUNT_WIDTH-1:0] byte_idx_reg;

    logic                  data_accept;
    logic                  push;
    logic                  pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RESET;
            mask_reg   <= MASK_RESET;
            hit_reg    <= HIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_MASK:   mask_reg   <= cfg_data;
                CFG_HIT:    hit_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign data_accept = data_valid && !data_stall;

    // Input register.
    always_ff @(posedge clk)
    begin
        if (data_accept)
        begin
            s1_byte_reg  <= data_byte;
            s1_close_reg <= close_list;
        end
    end

    assign mask_w    = HASH_WIDTH'(mask_reg);
    assign hit_w     = HASH_WIDTH'(hit_reg);
    assign hash_next = ({hash_reg[HASH_WIDTH-2:0], 1'b0} ^ HASH_WIDTH'(s1_byte_reg)) & mask_w;
    assign hit_now   = (hash_next == hit_w);
    assign run_inc   = (run_reg < RUN_MAX) ? run_reg + RUN_WIDTH'(1) : run_reg;
    assign run_next  = (hit_now || s1_close_reg) ? '0 : run_inc;

    // Hash and run count state, plus the per-word decision register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_hit_reg   <= 1'b0;
            s2_close_reg <= 1'b0;
            hash_reg     <= HASH_WIDTH'(HIT_RESET);
            run_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= data_accept;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && enable_reg)
            begin
                hash_reg     <= hash_next;
                run_reg      <= run_next;
                s2_hit_reg   <= hit_now;
                s2_close_reg <= s1_close_reg;
            end
            else
            begin
                s2_hit_reg   <= 1'b0;
                s2_close_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_len_reg <= run_inc;
        end
    end

    rhce_encoder u_encoder
    (
        .run_len (s2_len_reg),
        .hit     (s2_hit_reg),
        .close   (s2_close_reg),
        .rec     (enc_rec)
    );

    assign push = s2_valid_reg && (s2_hit_reg || s2_close_reg);

    // Output record queue.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_mem[wr_ptr_reg] <= enc_rec;
        end
    end

    assign head        = rec_mem[rd_ptr_reg];
    assign code_valid  = (fill_reg != '0);
    assign code_byte   = head.bytes[byte_idx_reg];
    assign last_of_run = (byte_idx_reg == head.count - CODE_COUNT_WIDTH'(1));
    assign pop         = code_valid && !code_stall && last_of_run;

    always_comb
    begin
        case ({push, pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
            byte_idx_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg   <= rd_ptr_reg + PTR_W'(1);
                byte_idx_reg <= '0;
            end
            else if (code_valid && !code_stall)
            begin
                byte_idx_reg <= byte_idx_reg + CODE_COUNT_WIDTH'(1);
            end
        end
    end

    // Reserve a queue slot for every word still in the pipeline.
    assign occupancy  = {1'b0, fill_reg} + (CNT_W + 1)'(s1_valid_reg)
                      + (CNT_W + 1)'(s2_valid_reg);
    assign data_stall = (occupancy >= (CNT_W + 1)'(FIFO_DEPTH));

    a_queue_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((fill_reg < CNT_W'(FIFO_DEPTH)) || pop))
        else $error("record written into a full queue");

    a_index_in_record : assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (byte_idx_reg < head.count))
        else $error("code byte index beyond record length");

    a_pop_restarts_index : assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (byte_idx_reg == '0))
        else $error("byte index not cleared after record pop");

endmodule

`default_nettype wire

// ----- tb/tb_rolling_hash_chunk_length_encoder.sv -----
// Self-checking testbench for the rolling hash chunk length encoder.
module tb_rolling_hash_chunk_length_encoder
    import rhce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NONE = 2'd3;
    localparam int RANDOM_ITEMS     = 100;
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD_CYCLES = 64;

    class chunk_code_scoreboard;
        typedef struct packed {
            logic [7:0] code;
            logic       last;
        } code_word_t;

        bit                 enable;
        bit [15:0]          mask;
        bit [15:0]          hit;
        bit [15:0]          hash;
        bit [RUN_WIDTH-1:0] run;
        code_word_t         expected_codes[$];
        int                 errors;

        function new();
            enable = ENABLE_RESET;
            mask   = MASK_RESET;
            hit    = HIT_RESET;
            hash   = HIT_RESET;
            run    = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
            case (idx)
                CFG_ENABLE: enable = data[0];
                CFG_MASK:   mask   = data;
                CFG_HIT:    hit    = data;
                default:    ;
            endcase
        endfunction

        // low byte that makes the next hash equal the hit value where the upper bits allow it
        function bit [7:0] hit_byte();
            bit [15:0] t;
            t = (hash << 1) ^ hit;
            return t[7:0];
        endfunction

        function void note_word(logic [7:0] b, logic c);
            bit [7:0]   codes[$];
            bit [31:0]  v;
            code_word_t w;
            if (!enable)
                return;
            hash = ((hash << 1) ^ {8'h00, b}) & mask;
            if (run < RUN_MAX)
                run++;
            if (hash == hit)
            begin
                if (run < LEN_TWO)
                    codes.insert(codes.size(), run[7:0] + SHORT_BASE);
                else if (run < LEN_THREE)
                begin
                    v = 32'(run - LEN_TWO);
                    codes.insert(codes.size(), v[15:8]);
                    codes.insert(codes.size(), v[7:0]);
                end
                else if (run < LEN_FOUR)
                begin
                    v = 32'(run - LEN_THREE);
                    codes.insert(codes.size(), v[23:16] + THREE_BASE);
                    codes.insert(codes.size(), v[15:8]);
                    codes.insert(codes.size(), v[7:0]);
                end
                else
                begin
                    v = 32'(run - LEN_FOUR);
                    codes.insert(codes.size(), v[31:24] + FOUR_BASE);
                    codes.insert(codes.size(), v[23:16]);
                    codes.insert(codes.size(), v[15:8]);
                    codes.insert(codes.size(), v[7:0]);
                end
                run = '0;
            end
            if (c)
            begin
                codes.insert(codes.size(), END_MARK);
                run = '0;
            end
            foreach (codes[i])
            begin
                w.code = codes[i];
                w.last = (i == codes.size() - 1);
                expected_codes.insert(expected_codes.size(), w);
            end
        endfunction

        function void check_code(logic [7:0] code, logic last);
            code_word_t w;
            if (expected_codes.size() == 0)
            begin
                $error("code_byte %0h (last_of_run %0b) arrived with nothing expected", code, last);
                errors++;
                return;
            end
            w = expected_codes[0];
            expected_codes.delete(0);
            if (code !== w.code)
            begin
                $error("code_byte mismatch: expected %0h, actual %0h", w.code, code);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last_of_run mismatch: expected %0b, actual %0b", w.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;
    logic                       data_valid;
    logic                       data_stall;
    logic [7:0]                 data_byte;
    logic                       close_list;
    logic                       code_valid;
    logic                       code_stall;
    logic [7:0]                 code_byte;
    logic                       last_of_run;

    chunk_code_scoreboard sb = new();

    int gap_pct   = 0;
    int stall_pct = 0;
    bit long_hold = 1'b0;

    rolling_hash_chunk_length_encoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_valid  (data_valid),
        .data_stall  (data_stall),
        .data_byte   (data_byte),
        .close_list  (close_list),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .code_byte   (code_byte),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #200_000;
        $display("tb_rolling_hash_chunk_length_encoder: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && code_valid && !code_stall)
            sb.check_code(code_byte, last_of_run);
    end

    // receiver: short random stall bursts, or one long hold-off on request
    initial
    begin
        code_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                code_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                code_stall <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(99) < stall_pct)
            begin
                code_stall <= 1'b1;
                repeat ($urandom_range(3, 1) - 1) @(posedge clk);
            end
            else
                code_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic c);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        close_list <= c;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        sb.note_word(b, c);
    endtask

    task automatic random_word(input int hit_pct, input int close_pct);
        logic [7:0] b;
        b = ($urandom_range(99) < hit_pct) ? sb.hit_byte() : 8'($urandom);
        send_word(b, $urandom_range(99) < close_pct);
    endtask

    task automatic drain();
        data_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic en, input logic [15:0] m, input logic [15:0] h,
                              input bit junk);
        logic [CFG_WIDTH-1:0] en_word;
        en_word    = CFG_WIDTH'($urandom);
        en_word[0] = en;
        drain();
        if (junk)
            write_reg(CFG_NONE, CFG_WIDTH'($urandom));
        write_reg(CFG_ENABLE, en_word);
        write_reg(CFG_MASK, m);
        write_reg(CFG_HIT, h);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // mask 0 keeps the hash at 0; hit 1 never matches, hit 0 always does
    task automatic run_to_length(input int unsigned len);
        set_config(1'b1, 16'h0000, 16'h0001, 1'b0);
        send_word(8'($urandom), 1'b1);
        repeat (len - 1) send_word(8'($urandom), 1'b0);
        set_config(1'b1, 16'h0000, 16'h0000, 1'b0);
        send_word(8'($urandom), 1'b0);
    endtask

    function automatic int pick3(input int a, input int b, input int c);
        case ($urandom_range(2))
            0:       return a;
            1:       return b;
            default: return c;
        endcase
    endfunction

    initial
    begin
        int          items;
        int          n;
        int          kind;
        int          hit_pct;
        int          close_pct;
        logic        en;
        logic [15:0] m;
        logic [15:0] h;

        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_ENABLE;
        cfg_data   <= '0;
        data_valid <= 1'b0;
        data_byte  <= '0;
        close_list <= 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 25;
        stall_pct = 25;

        // reset settings: plain bytes and a lone end marker
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);

        set_config(1'b1, 16'h00FF, 16'h00FF, 1'b0);
        send_word(sb.hit_byte(), 1'b0);
        send_word(sb.hit_byte(), 1'b1);
        send_word(8'h3C, 1'b1);
        send_word(8'hC3, 1'b0);

        // full mask: ones climb through the hash until it hits
        set_config(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        repeat (10) send_word(sb.hit_byte(), 1'b0);
        send_word(sb.hit_byte(), 1'b1);

        set_config(1'b1, 16'h0000, 16'h0000, 1'b1);
        send_word(8'h81, 1'b0);
        send_word(8'h7E, 1'b1);

        // disabled: bytes and closes pass with no output
        set_config(1'b0, 16'hFFFF, 16'h0000, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);

        // code length boundaries
        gap_pct   = 10;
        stall_pct = 20;
        run_to_length(63);
        run_to_length(64);

        // receiver holds off while the sender keeps offering words
        set_config(1'b1, 16'h0000, 16'h0000, 1'b0);
        gap_pct   = 0;
        stall_pct = 0;
        long_hold = 1'b1;
        repeat (40) random_word(0, 20);

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(5);
            en   = 1'b1;
            m    = 16'($urandom);
            h    = 16'($urandom);
            case (kind)
                0:
                begin
                    m = 16'h00FF;
                    h = h & m;
                end
                1:       m = 16'hFFFF;
                2:       h = h & m;
                3:
                begin
                    m = 16'h0000;
                    h = 16'h0000;
                end
                4:
                begin
                    m = 16'h01FF;
                    h = h & m;
                end
                default: en = 1'b0;
            endcase
            gap_pct   = pick3(0, 20, 50);
            stall_pct = pick3(0, 20, 50);
            hit_pct   = pick3(2, 25, 60);
            close_pct = pick3(0, 5, 15);
            set_config(en, m, h, $urandom_range(7) == 0);
            n = (hit_pct == 2) ? $urandom_range(90, 40) : $urandom_range(40, 15);
            repeat (n)
            begin
                random_word(hit_pct, close_pct);
                if (en)
                    items++;
            end
        end

        // closing stretch with no idling on either side
        gap_pct   = 0;
        stall_pct = 0;
        set_config(1'b1, 16'h00FF, 16'h0033, 1'b0);
        repeat (30) random_word(30, 10);

        data_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_rolling_hash_chunk_length_encoder: done, clean");
        else
            $display("tb_rolling_hash_chunk_length_encoder: done, errors");
        $finish;
    end

endmodule
